@@ hw/rtl/fsp_pkg.sv @@
`timescale 1ns / 1ps

package fsp_pkg;

    localparam int unsigned CH_W    = 8;
    localparam int unsigned NUM_W   = 11;
    localparam int unsigned PREC_W  = 12;
    localparam int unsigned KIND_W  = 3;
    localparam int unsigned CNT_W   = 3;
    localparam int unsigned SUM_W   = 14;

    localparam logic [NUM_W-1:0] NUM_LIMIT = NUM_W'(1024);

    localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;  // '0'
    localparam logic [CH_W-1:0] CH_NINE   = 8'h39;  // '9'
    localparam logic [CH_W-1:0] CH_LT     = 8'h3C;  // '<'
    localparam logic [CH_W-1:0] CH_GT     = 8'h3E;  // '>'
    localparam logic [CH_W-1:0] CH_CARET  = 8'h5E;  // '^'
    localparam logic [CH_W-1:0] CH_D      = 8'h64;  // 'd'
    localparam logic [CH_W-1:0] CH_DOT    = 8'h2E;  // '.'
    localparam logic [CH_W-1:0] CH_F      = 8'h66;  // 'f'

    localparam logic [CNT_W-1:0] CNT_MAX    = 3'd7;
    localparam logic [CNT_W-1:0] LEN_UPPER  = 3'd5;
    localparam logic [CNT_W-1:0] LEN_TRIM   = 3'd4;

    typedef enum logic [2:0] {
        PH_START,
        PH_ALIGN,
        PH_WIDTH,
        PH_AFTER_D,
        PH_PREC,
        PH_AFTER_F,
        PH_DEAD
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        FK_UPPER   = 3'd0,
        FK_LOWER   = 3'd1,
        FK_TRIM    = 3'd2,
        FK_LEFT    = 3'd3,
        FK_RIGHT   = 3'd4,
        FK_CENTER  = 3'd5,
        FK_DECIMAL = 3'd6,
        FK_FIXED   = 3'd7
    } fmt_kind_t;

    typedef enum logic [1:0] {
        AL_LEFT   = 2'd0,
        AL_RIGHT  = 2'd1,
        AL_CENTER = 2'd2
    } align_t;

    // kw_alive bit positions
    localparam int unsigned KW_UPPER = 0;
    localparam int unsigned KW_LOWER = 1;
    localparam int unsigned KW_TRIM  = 2;

    typedef struct packed {
        logic [CNT_W-1:0] char_count;
        phase_t           phase;
        logic [2:0]       kw_alive;
        logic [NUM_W-1:0] width_acc;
        logic [NUM_W-1:0] prec_acc;
        logic             width_seen;
        logic             prec_seen;
        logic             lead_zero;
        align_t           align;
        logic             spec_err;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        char_count: '0,
        phase:      PH_START,
        kw_alive:   3'b111,
        width_acc:  '0,
        prec_acc:   '0,
        width_seen: 1'b0,
        prec_seen:  1'b0,
        lead_zero:  1'b0,
        align:      AL_LEFT,
        spec_err:   1'b0
    };

    typedef struct packed {
        logic                     ok;
        fmt_kind_t                format_kind;
        logic [NUM_W-1:0]         field_width;
        logic signed [PREC_W-1:0] precision;
        logic                     zero_fill;
    } result_t;

    function automatic logic [CH_W-1:0] upper_char(input logic [CNT_W-1:0] idx);
        logic [CH_W-1:0] c;
        case (idx)
            3'd0:    c = 8'h75;  // u
            3'd1:    c = 8'h70;  // p
            3'd2:    c = 8'h70;  // p
            3'd3:    c = 8'h65;  // e
            3'd4:    c = 8'h72;  // r
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [CH_W-1:0] lower_char(input logic [CNT_W-1:0] idx);
        logic [CH_W-1:0] c;
        case (idx)
            3'd0:    c = 8'h6C;  // l
            3'd1:    c = 8'h6F;  // o
            3'd2:    c = 8'h77;  // w
            3'd3:    c = 8'h65;  // e
            3'd4:    c = 8'h72;  // r
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [CH_W-1:0] trim_char(input logic [CNT_W-1:0] idx);
        logic [CH_W-1:0] c;
        case (idx)
            3'd0:    c = 8'h74;  // t
            3'd1:    c = 8'h72;  // r
            3'd2:    c = 8'h69;  // i
            3'd3:    c = 8'h6D;  // m
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

@@ hw/rtl/fsp_if.sv @@
`timescale 1ns / 1ps

interface fsp_in_if;
    import fsp_pkg::*;

    logic             valid;
    logic             ready;
    logic [CH_W-1:0]  ch;
    logic             last;
    logic             value_kind;

    modport source (output valid, ch, last, value_kind, input ready);
    modport sink   (input valid, ch, last, value_kind, output ready);
endinterface

interface fsp_out_if;
    import fsp_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     ok;
    logic [KIND_W-1:0]        format_kind;
    logic [NUM_W-1:0]         field_width;
    logic signed [PREC_W-1:0] precision;
    logic                     zero_fill;

    modport source (output valid, ok, format_kind, field_width, precision, zero_fill,
                    input ready);
    modport sink   (input valid, ok, format_kind, field_width, precision, zero_fill,
                    output ready);
endinterface

@@ hw/rtl/format_spec_parser_unit.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Payload                                            Transfer
// spec_in   in   ch[7:0], last, value_kind                          valid & ready
// res_out   out  ok, format_kind[2:0], field_width[10:0],           valid & ready
//                precision[11:0] (signed), zero_fill
//
// One character per cycle. A character is parsed in the cycle it transfers; the
// result of a specifier (only on its last character) appears in the output
// register on the next cycle. rst_n clears parse state and the output valid.
// spec_in.ready drops only while a result waits in the output register and
// res_out.ready is low; otherwise characters flow back to back.
module format_spec_parser_unit (
    input  logic      clk,
    input  logic      rst_n,
    fsp_in_if.sink    spec_in,
    fsp_out_if.source res_out
);
    import fsp_pkg::*;

    parse_state_t state_reg;
    parse_state_t state_step;
    parse_state_t state_next;
    result_t      step_res;
    result_t      res_next;
    result_t      res_reg;
    logic         out_valid_reg;
    logic         out_valid_next;
    logic         in_xfer;
    logic         kind_int;
    logic         kind_match;

    fsp_step u_step (
        .state      (state_reg),
        .ch         (spec_in.ch),
        .state_next (state_step),
        .result     (step_res)
    );

    // Output register acts as the boundary: input stalls only on a held result.
    assign spec_in.ready = !out_valid_reg || res_out.ready;
    assign in_xfer       = spec_in.valid && spec_in.ready;

    // Last character closes the spec; state falls back to its start values.
    always_comb
    begin
        state_next = state_reg;
        if (in_xfer)
            state_next = spec_in.last ? STATE_RESET : state_step;
    end

    // Decimal and fixed forms want an integer value, the rest a string.
    assign kind_int   = (step_res.format_kind == FK_DECIMAL) ||
                        (step_res.format_kind == FK_FIXED);
    assign kind_match = (kind_int == spec_in.value_kind);

    always_comb
    begin
        res_next = step_res;
        if (!(step_res.ok && kind_match))
            res_next = '{ok: 1'b0, format_kind: FK_UPPER, field_width: '0,
                         precision: '1, zero_fill: 1'b0};
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_xfer && spec_in.last)
            out_valid_next = 1'b1;
        else if (res_out.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_xfer && spec_in.last)
            res_reg <= res_next;
    end

    assign res_out.valid       = out_valid_reg;
    assign res_out.ok          = res_reg.ok;
    assign res_out.format_kind = res_reg.format_kind;
    assign res_out.field_width = res_reg.field_width;
    assign res_out.precision   = res_reg.precision;
    assign res_out.zero_fill   = res_reg.zero_fill;

endmodule

@@ hw/rtl/fsp_step.sv @@
`timescale 1ns / 1ps

// One character of parsing: next state plus the result that a last character yields.
module fsp_step (
    input  fsp_pkg::parse_state_t    state,
    input  logic [fsp_pkg::CH_W-1:0] ch,
    output fsp_pkg::parse_state_t    state_next,
    output fsp_pkg::result_t         result
);
    import fsp_pkg::*;

    logic             is_digit;
    logic [3:0]       digit;
    logic [NUM_W-1:0] acc_in;
    logic [SUM_W-1:0] acc_sum;
    logic             acc_over;
    logic [NUM_W-1:0] acc_out;
    logic             use_prec;
    parse_state_t     s;
    logic             kw_upper_hit;
    logic             kw_lower_hit;
    logic             kw_trim_hit;
    logic             valid;
    fmt_kind_t        kind;

    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign digit    = 4'(ch - CH_ZERO);

    // Shared x10 + digit accumulator; saturates at the limit and flags overflow.
    assign use_prec = (state.phase == PH_PREC);
    assign acc_in   = use_prec ? state.prec_acc : state.width_acc;
    assign acc_sum  = (SUM_W'(acc_in) << 3) + (SUM_W'(acc_in) << 1) + SUM_W'(digit);
    assign acc_over = acc_sum > SUM_W'(NUM_LIMIT);
    assign acc_out  = acc_over ? NUM_LIMIT : acc_sum[NUM_W-1:0];

    always_comb
    begin
        s = state;

        // keyword matching
        if (state.char_count >= LEN_UPPER || ch != upper_char(state.char_count))
            s.kw_alive[KW_UPPER] = 1'b0;
        if (state.char_count >= LEN_UPPER || ch != lower_char(state.char_count))
            s.kw_alive[KW_LOWER] = 1'b0;
        if (state.char_count >= LEN_TRIM || ch != trim_char(state.char_count))
            s.kw_alive[KW_TRIM] = 1'b0;
        if (state.char_count != CNT_MAX)
            s.char_count = state.char_count + 1'b1;

        unique case (state.phase)
            PH_START:
            begin
                if (ch == CH_LT)
                begin
                    s.align = AL_LEFT;
                    s.phase = PH_ALIGN;
                end
                else if (ch == CH_GT)
                begin
                    s.align = AL_RIGHT;
                    s.phase = PH_ALIGN;
                end
                else if (ch == CH_CARET)
                begin
                    s.align = AL_CENTER;
                    s.phase = PH_ALIGN;
                end
                else if (ch == CH_ZERO)
                begin
                    s.lead_zero = 1'b1;
                    s.phase     = PH_WIDTH;
                end
                else if (is_digit)
                begin
                    s.width_acc  = acc_out;
                    s.spec_err   = state.spec_err | acc_over;
                    s.width_seen = 1'b1;
                    s.phase      = PH_WIDTH;
                end
                else if (ch == CH_DOT)
                    s.phase = PH_PREC;
                else
                    s.phase = PH_DEAD;
            end
            PH_ALIGN:
            begin
                if (is_digit)
                begin
                    s.width_acc  = acc_out;
                    s.spec_err   = state.spec_err | acc_over;
                    s.width_seen = 1'b1;
                end
                else
                    s.phase = PH_DEAD;
            end
            PH_WIDTH:
            begin
                if (is_digit)
                begin
                    s.width_acc  = acc_out;
                    s.spec_err   = state.spec_err | acc_over;
                    s.width_seen = 1'b1;
                end
                else if (ch == CH_D)
                    s.phase = PH_AFTER_D;
                else if (ch == CH_DOT)
                begin
                    if (state.lead_zero || (state.width_seen && state.width_acc == '0))
                        s.phase = PH_DEAD;
                    else
                        s.phase = PH_PREC;
                end
                else
                    s.phase = PH_DEAD;
            end
            PH_PREC:
            begin
                if (is_digit)
                begin
                    s.prec_acc  = acc_out;
                    s.spec_err  = state.spec_err | acc_over;
                    s.prec_seen = 1'b1;
                end
                else if (ch == CH_F)
                    s.phase = PH_AFTER_F;
                else
                    s.phase = PH_DEAD;
            end
            default:
                s.phase = PH_DEAD;
        endcase
    end

    assign state_next = s;

    assign kw_upper_hit = (s.char_count == LEN_UPPER) && s.kw_alive[KW_UPPER];
    assign kw_lower_hit = (s.char_count == LEN_UPPER) && s.kw_alive[KW_LOWER];
    assign kw_trim_hit  = (s.char_count == LEN_TRIM) && s.kw_alive[KW_TRIM];

    always_comb
    begin
        valid     = 1'b0;
        kind      = FK_UPPER;
        result    = '{ok: 1'b0, format_kind: FK_UPPER, field_width: '0,
                      precision: '1, zero_fill: 1'b0};
        if (kw_upper_hit)
        begin
            valid = 1'b1;
            kind  = FK_UPPER;
        end
        else if (kw_lower_hit)
        begin
            valid = 1'b1;
            kind  = FK_LOWER;
        end
        else if (kw_trim_hit)
        begin
            valid = 1'b1;
            kind  = FK_TRIM;
        end
        else if (!s.spec_err)
        begin
            if (s.phase == PH_ALIGN && s.width_seen && s.width_acc != '0)
            begin
                valid = 1'b1;
                kind  = fmt_kind_t'(KIND_W'(FK_LEFT) + KIND_W'(s.align));
            end
            else if (s.phase == PH_AFTER_D && s.width_seen && s.width_acc != '0)
            begin
                valid = 1'b1;
                kind  = FK_DECIMAL;
            end
            else if (s.phase == PH_AFTER_F && s.prec_seen && s.prec_acc != '0)
            begin
                valid = 1'b1;
                kind  = FK_FIXED;
            end
        end

        if (valid)
        begin
            result.ok          = 1'b1;
            result.format_kind = kind;
            if (kind != FK_UPPER && kind != FK_LOWER && kind != FK_TRIM)
                result.field_width = s.width_acc;
            if (kind == FK_FIXED)
                result.precision = $signed({1'b0, s.prec_acc});
            if (kind == FK_DECIMAL)
                result.zero_fill = s.lead_zero;
        end
        // kind check against the value kind is applied at the top level
    end

endmodule
